@@ hw/rtl/mal_pkg.sv @@
// ----------------------------------------------------------------------------
// mal_pkg
// Shared types and codes for the most-recently-used address list.
// ----------------------------------------------------------------------------
package mal_pkg;

    localparam int ADDR_W   = 48;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 3;
    localparam int COUNT_W  = 4;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAP_ZERO  = 2'd2;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 4'd8;

    // what a cell loads at the end of an operation
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT,
        CELL_CLEAR
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

endpackage

@@ hw/rtl/mru_address_list.sv @@
// ----------------------------------------------------------------------------
// mru_address_list
// Most-recently-used list of 48-bit device addresses built as a row of cells.
// ----------------------------------------------------------------------------
// A transaction is accepted in the idle state. In the compare state every cell
// compares its stored address; in the update state the first match is found
// and the affected cells load at once from a neighbour or the new address. The
// next transaction is taken in the cycle after the update, so a new item is only
// taken once the last one is through; a stalled result holds the update cycle
// until the output register is free. Update moves or inserts an address at the
// front, remove deletes it and closes the gap, lookup reports its position.
// Capacity is written through capacity_we/capacity_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce;
// values above MAX_ENTRIES act as MAX_ENTRIES.
module mru_address_list
    import mal_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  capacity_we,
    input  logic [COUNT_W-1:0]    capacity_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // opcode [1:0], address [49:2], zero [55:50]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status [1:0], position [4:2], found [5], link_count [9:6], zero [15:10]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = (NW > COUNT_W) ? NW : COUNT_W;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0]  capacity_reg;
    logic [NW-1:0]       linked_count_reg;
    logic [NW-1:0]       linked_count_next;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic in_fire;
    logic cmp_en;
    logic upd_go;

    logic [KW-1:0]          cap_ext;
    logic [NW-1:0]          n_used;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic                   hit;
    logic [IW-1:0]          pos;
    logic [STATUS_W-1:0]    status;

    logic [ADDR_W-1:0] cell_data [MAX_ENTRIES];
    cell_op_t          cell_op   [MAX_ENTRIES];

    // ---------------------------------------------------------------- control
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cmp_en  = (state_reg == S_CMP);
    assign upd_go  = (state_reg == S_UPD) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_CMP;
            S_CMP:   state_next = S_UPD;
            S_UPD:   if (upd_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg <= s_axis_tdata[OPCODE_W-1:0];
            addr_reg   <= s_axis_tdata[OPCODE_W +: ADDR_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (capacity_we)
        begin
            capacity_reg <= capacity_wdata;
        end
    end

    // cells in use is min(capacity, depth)
    always_comb
    begin
        cap_ext = KW'(capacity_reg);
        if (cap_ext > KW'(MAX_ENTRIES))
        begin
            n_used = NW'(MAX_ENTRIES);
        end
        else
        begin
            n_used = NW'(cap_ext);
        end
    end

    // ------------------------------------------------------------ first match
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_vec[i] = match_vec[i] && (NW'(i) < n_used);
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                pos = IW'(i);
            end
        end
        hit = |hit_vec;
    end

    // ------------------------------------------------------- per-cell control
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (upd_go)
            begin
                priority if (opcode_reg == OP_UPDATE)
                begin
                    if (hit)
                    begin
                        if (i == 0)
                            cell_op[i] = CELL_LOAD;
                        else if (IW'(i) <= pos)
                            cell_op[i] = CELL_PREV;
                    end
                    else if (n_used != '0)
                    begin
                        if (i == 0)
                            cell_op[i] = CELL_LOAD;
                        else if (NW'(i) < n_used)
                            cell_op[i] = CELL_PREV;
                    end
                end
                else if (opcode_reg == OP_REMOVE)
                begin
                    if (hit && (IW'(i) >= pos))
                    begin
                        if (NW'(i + 1) < n_used)
                            cell_op[i] = CELL_NEXT;
                        else if (NW'(i + 1) == n_used)
                            cell_op[i] = CELL_CLEAR;
                    end
                end
                else
                begin
                    // lookup and the unused code leave every cell alone
                    cell_op[i] = CELL_HOLD;
                end
            end
        end
    end

    // ------------------------------------------------------------- cell chain
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [ADDR_W-1:0] prev_d;
        logic [ADDR_W-1:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = addr_reg;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[g-1];
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[g+1];
        end

        mal_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmp_en    (cmp_en),
            .addr      (addr_reg),
            .cell_op   (cell_op[g]),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[g]),
            .match     (match_vec[g])
        );
    end

    // ------------------------------------------------------ count and result
    always_comb
    begin
        linked_count_next = linked_count_reg;
        status            = ST_OK;
        unique case (opcode_reg)
            OP_UPDATE:
            begin
                if (!hit)
                begin
                    if (n_used == '0)
                        status = ST_CAP_ZERO;
                    else if (linked_count_reg < n_used)
                        linked_count_next = linked_count_reg + NW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    if (linked_count_reg != '0)
                        linked_count_next = linked_count_reg - NW'(1);
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // lookup, and the unused code behaves the same
                if (!hit)
                    status = ST_NOT_FOUND;
            end
        endcase

        out_data_next = '0;
        out_data_next[1:0] = status;
        out_data_next[4:2] = hit ? POS_W'(pos) : '0;
        out_data_next[5]   = hit;
        out_data_next[9:6] = COUNT_W'(linked_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (upd_go)
            begin
                linked_count_reg <= linked_count_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_UPD))
        else $error("result appeared without an update cycle");

    a_accept_starts_compare: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CMP))
        else $error("accepted transaction did not enter compare");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        linked_count_reg <= NW'(MAX_ENTRIES))
        else $error("link count above depth");

    a_fail_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && (status != ST_OK)) |-> !hit)
        else $error("error status with a hit");
`endif

endmodule

@@ hw/rtl/mal_cell.sv @@
// ----------------------------------------------------------------------------
// mal_cell
// One list cell: holds an address, compares it and loads the new address, a neighbour's or zero.
// ----------------------------------------------------------------------------
module mal_cell
    import mal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmp_en,
    input  logic [ADDR_W-1:0] addr,
    input  cell_op_t          cell_op,
    input  logic [ADDR_W-1:0] prev_data,
    input  logic [ADDR_W-1:0] next_data,
    output logic [ADDR_W-1:0] data,
    output logic              match
);

    logic [ADDR_W-1:0] data_reg;
    logic [ADDR_W-1:0] data_next;
    logic              match_reg;

    always_comb
    begin
        unique case (cell_op)
            CELL_HOLD:  data_next = data_reg;
            CELL_LOAD:  data_next = addr;
            CELL_PREV:  data_next = prev_data;
            CELL_NEXT:  data_next = next_data;
            CELL_CLEAR: data_next = '0;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            match_reg <= (data_reg == addr);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ bench/tb_mru_address_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mru_address_list
// Self-checking bench for the most-recently-used address list. A directed
// table covers reset contents, field extremes, every opcode and the capacity
// corner cases. Random phases then run at several capacities over a small
// address pool, so that hits, moves and removes are frequent. Each result is
// checked against the bench's behavioural model of the list or a typed row's result.
// ----------------------------------------------------------------------------
module tb_mru_address_list
    import mal_pkg::*;
();

    localparam int LIST_DEPTH      = 8;
    localparam int POOL_SIZE       = 12;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 9;
    localparam int DIRECTED_ROWS   = 27;
    localparam int HOLD_AT_RESULT  = 300;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 100000;

    // the fourth opcode is not used by the block and behaves as a lookup
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic                found;
        logic [COUNT_W-1:0]  link_count;
    } mru_result_t;

    typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [COUNT_W-1:0]    cap;
        logic [OPCODE_W-1:0]   op;
        logic [ADDR_W-1:0]     addr;
        bit                    typed;
        mru_result_t           want;
    } table_row_t;

    localparam mru_result_t NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  capacity_we;
    logic [COUNT_W-1:0]    capacity_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // opcode [1:0], address [49:2], zero [55:50]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // status [1:0], position [4:2], found [5], link_count [9:6], zero [15:10]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // model of the list
    logic [ADDR_W-1:0]  mru_cells [LIST_DEPTH];
    logic [COUNT_W-1:0] mru_links;
    logic [COUNT_W-1:0] mru_capacity;

    mru_result_t        mru_expected [$];
    logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  hit_total;
    int  cap_zero_total;
    int  cap_writes;
    int  cycle_count;
    bit  source_busy;
    bit  long_hold_done;

    table_row_t directed_rows [DIRECTED_ROWS] = '{
        // address zero matches the first cleared cell
        '{ROW_ITEM, 4'd0, OP_LOOKUP, 48'h0000_0000_0000, 1'b1, '{ST_OK, 3'd0, 1'b1, 4'd0}},
        '{ROW_ITEM, 4'd0, OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{ST_NOT_FOUND, 3'd0, 1'b0, 4'd0}},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_OK, 3'd0, 1'b0, 4'd1}},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_0000_0001, 1'b1, '{ST_OK, 3'd0, 1'b0, 4'd2}},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'hAAAA_AAAA_AAAA, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h5555_5555_5555, 1'b0, NO_RESULT},
        // hit further down moves to the front
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_0000_0001, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_REMOVE, 48'hAAAA_AAAA_AAAA, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_REMOVE, 48'h0000_0012_3456, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_SPARE,  48'h0000_0000_0001, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_REMOVE, 48'h0000_0000_0000, 1'b0, NO_RESULT},
        // fill past the depth so the count reaches the depth and the tail drops
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h8000_0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h4000_0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_FFFF_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h1234_5678_9ABC, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'hFEDC_BA98_7654, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0F0F_0F0F_0F0F, 1'b0, NO_RESULT},
        // capacity above the depth acts as the depth
        '{ROW_CAP,  4'd15, OP_LOOKUP, 48'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_LOOKUP, 48'h8000_0000_0000, 1'b0, NO_RESULT},
        '{ROW_CAP,  4'd0, OP_LOOKUP, 48'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_0000_0001, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_LOOKUP, 48'h0000_0000_0000, 1'b0, NO_RESULT},
        // lowered capacity leaves the count above it
        '{ROW_CAP,  4'd3, OP_LOOKUP, 48'h0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 4'd0, OP_UPDATE, 48'h0000_0000_0777, 1'b0, NO_RESULT}
    };

    logic [COUNT_W-1:0] phase_caps [NUM_PHASES] = '{
        4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd12, 4'd8
    };

    mru_address_list #(
        .MAX_ENTRIES    (LIST_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[ADDR_W-1:0];
    endfunction

    // applies one operation to the model list and returns its result
    function automatic mru_result_t mru_apply(input logic [OPCODE_W-1:0] op,
                                              input logic [ADDR_W-1:0] addr);
        mru_result_t res;
        int          in_use;
        int          hit_at;
        res    = NO_RESULT;
        in_use = (mru_capacity > LIST_DEPTH) ? LIST_DEPTH : int'(mru_capacity);
        hit_at = -1;
        for (int i = in_use - 1; i >= 0; i--)
        begin
            if (mru_cells[i] == addr)
                hit_at = i;
        end

        if (op == OP_UPDATE)
        begin
            if (hit_at >= 0)
            begin
                for (int i = hit_at; i > 0; i--)
                    mru_cells[i] = mru_cells[i-1];
                mru_cells[0] = addr;
            end
            else if (in_use == 0)
            begin
                res.status = ST_CAP_ZERO;
                cap_zero_total++;
            end
            else
            begin
                for (int i = in_use - 1; i > 0; i--)
                    mru_cells[i] = mru_cells[i-1];
                mru_cells[0] = addr;
                if (mru_links < in_use)
                    mru_links++;
            end
        end
        else if (op == OP_REMOVE)
        begin
            if (hit_at >= 0)
            begin
                for (int i = hit_at; i + 1 < in_use; i++)
                    mru_cells[i] = mru_cells[i+1];
                mru_cells[in_use-1] = '0;
                if (mru_links > 0)
                    mru_links--;
            end
            else
                res.status = ST_NOT_FOUND;
        end
        else if (hit_at < 0)
            res.status = ST_NOT_FOUND;

        if (hit_at >= 0)
        begin
            res.position = hit_at[POS_W-1:0];
            res.found    = 1'b1;
            hit_total++;
        end
        res.link_count = mru_links;
        return res;
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input bit typed, input mru_result_t typed_result);
        int          gap;
        mru_result_t predicted;
        if ($urandom_range(0, 39) == 0)
            source_busy = !source_busy;
        gap = source_busy ? $urandom_range(0, 3) : 0;
        // valid only drops when a gap follows, never within the step it rises
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-ADDR_W-OPCODE_W){1'b0}}, addr, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = mru_apply(op, addr);
        mru_expected.push_back(typed ? typed_result : predicted);
        items_sent++;
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (mru_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        capacity_we    <= 1'b1;
        capacity_wdata <= value;
        @(posedge clk);
        capacity_we    <= 1'b0;
        mru_capacity = value;
        cap_writes++;
    endtask

    initial
    begin : stimulus
        logic [OPCODE_W-1:0] op;
        logic [ADDR_W-1:0]   addr;
        int                  pick;
        rst_n          <= 1'b0;
        capacity_we    <= 1'b0;
        capacity_wdata <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        foreach (mru_cells[i])
            mru_cells[i] = '0;
        mru_links    = '0;
        mru_capacity = CAPACITY_RESET;
        source_busy  = 1'b1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = random_address();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CAP)
                write_capacity(directed_rows[i].cap);
            else
                send_item(directed_rows[i].op, directed_rows[i].addr,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            // refresh part of the pool so each phase sees new addresses
            for (int k = 0; k < 4; k++)
                addr_pool[$urandom_range(2, POOL_SIZE - 1)] = random_address();
            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    op = OP_UPDATE;
                else if (pick < 14)
                    op = OP_REMOVE;
                else if (pick < 18)
                    op = OP_LOOKUP;
                else
                    op = OP_SPARE;
                if ($urandom_range(0, 4) == 0)
                    addr = random_address();
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(op, addr, 1'b0, NO_RESULT);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (mru_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d transactions in, %0d results checked, %0d capacity writes",
                 items_sent, results_seen, cap_writes);
        $display("summary: %0d hits, %0d zero-capacity updates, long output hold %0s",
                 hit_total, cap_zero_total, long_hold_done ? "applied" : "not reached");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : result_sink
        int          stall;
        bit          sink_busy;
        mru_result_t got;
        mru_result_t want;
        m_axis_tready <= 1'b0;
        sink_busy = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_busy = !sink_busy;
            stall = sink_busy ? $urandom_range(0, 3) : 0;
            // one long hold so the block backs up and stalls its input
            if (!long_hold_done && results_seen == HOLD_AT_RESULT)
            begin
                stall = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);

            got.status     = m_axis_tdata[1:0];
            got.position   = m_axis_tdata[4:2];
            got.found      = m_axis_tdata[5];
            got.link_count = m_axis_tdata[9:6];
            results_seen++;
            if (mru_expected.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction out: status %0d pos %0d found %0d count %0d",
                             got.status, got.position, got.found, got.link_count);
            end
            else
            begin
                want = mru_expected.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("result %0d mismatch: expected status %0d pos %0d found %0d count %0d",
                                 results_seen, want.status, want.position, want.found,
                                 want.link_count);
                        $display("    got status %0d pos %0d found %0d count %0d",
                                 got.status, got.position, got.found, got.link_count);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, mru_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
